// ===== design/crc8rx_pkg.sv =====
`default_nettype none

package crc8rx_pkg;

  localparam int MAX_PAYLOAD_DEF = 59;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 1'd0;
  localparam logic [15:0] TIMEOUT_RST = 16'd10000;

  localparam logic [7:0] SYNC_FIRST  = 8'hAA;
  localparam logic [7:0] SYNC_SECOND = 8'h55;
  localparam logic [7:0] CRC_POLY    = 8'h07;
  localparam logic [7:0] LINK_CMD    = 8'hF0;
  localparam logic [7:0] LEN_SAT     = 8'd63;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_END     = 1'b1;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_SYNC    = 3'd1;
  localparam logic [2:0] ST_TIMEOUT = 3'd2;
  localparam logic [2:0] ST_CRC     = 3'd3;
  localparam logic [2:0] ST_LONG    = 3'd4;
  localparam logic [2:0] ST_LINK    = 3'd5;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] payload_byte;
    logic [5:0] payload_index;
    logic [7:0] command;
    logic [5:0] frame_length;
    logic [2:0] status;
    logic [7:0] link_state;
  } out_item_t;

  typedef struct packed {
    logic      vld;
    out_item_t item;
  } res_t;

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== design/sync_crc8_frame_receiver.sv =====
// Synchronous framed-byte receiver with CRC-8 (poly 0x07, init 0) check.
// Input channel (in_valid/in_ready/in_item): each item is either one byte
// from the UART receiver or one time tick. Frames are 0xAA 0x55, command,
// length, payload, CRC. Result channel (out_valid/out_ready/out_item): one
// item per payload byte as it arrives (none for link-state frames) and one
// frame-end item with status ok, sync error, timeout, CRC error, too long
// or link-state frame. Many input items produce no result.
// Configuration: APB-style port, register 0 at address 0 holds the tick
// count between bytes in a frame at which it times out (reset 10000).
// An accepted input item loads the input register; one pass of frame logic
// then loads its result, if any, into the output register. The block
// accepts one input item per cycle while results are taken, the frame state
// updating with its unrolled CRC in one pass per item.
// When the receiver holds out_ready low, the pending result holds and the
// input register fills; in_ready then drops until the result is taken.
// Reset (rst_n low, synchronous) empties both registers, returns the frame
// logic to hunting for sync and clears the link-state byte.
`default_nettype none

module sync_crc8_frame_receiver #(
  parameter int MAX_PAYLOAD = crc8rx_pkg::MAX_PAYLOAD_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire crc8rx_pkg::in_item_t            in_item,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output crc8rx_pkg::out_item_t                out_item,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [crc8rx_pkg::CFG_AW-1:0]   paddr,
  input  wire logic [crc8rx_pkg::CFG_DW-1:0]   pwdata,
  output logic      [crc8rx_pkg::CFG_DW-1:0]   prdata,
  output logic                                 pready
);

  logic                  in_vld_r, in_vld_nxt;
  crc8rx_pkg::in_item_t  in_item_r;
  logic                  out_vld_r, out_vld_nxt;
  crc8rx_pkg::out_item_t out_item_r;
  logic                  step;
  logic                  in_acc;
  logic [15:0]           timeout_ticks;
  crc8rx_pkg::res_t      res;

  crc8rx_cfg u_cfg (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .timeout_ticks (timeout_ticks)
  );

  crc8rx_fsm #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_fsm (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (step),
    .item          (in_item_r),
    .timeout_ticks (timeout_ticks),
    .res           (res)
  );

  assign step     = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || step;
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_acc) begin
      in_vld_nxt = 1'b1;
    end else if (step) begin
      in_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r;
    if (step && res.vld) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_item_r <= in_item;
    end
    if (step && res.vld) begin
      out_item_r <= res.item;
    end
  end

  assign out_valid = out_vld_r;
  assign out_item  = out_item_r;

`ifndef SYNTHESIS
  a_payload_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.kind == crc8rx_pkg::KIND_PAYLOAD
      |-> out_item.status == crc8rx_pkg::ST_OK)
    else $error("payload item with nonzero status");

  a_end_fields_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.kind == crc8rx_pkg::KIND_END
      |-> out_item.payload_byte == 8'd0 && out_item.payload_index == 6'd0)
    else $error("frame-end item carries payload fields");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.status <= crc8rx_pkg::ST_LINK)
    else $error("status code out of range");

  a_stall_only_on_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> in_vld_r && out_valid && !out_ready)
    else $error("input stalled without output backpressure");

  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("registers not empty after reset");
`endif

endmodule

`default_nettype wire

// ===== design/crc8rx_cfg.sv =====
`default_nettype none

module crc8rx_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [crc8rx_pkg::CFG_AW-1:0]   paddr,
  input  wire logic [crc8rx_pkg::CFG_DW-1:0]   pwdata,
  output logic      [crc8rx_pkg::CFG_DW-1:0]   prdata,
  output logic                                 pready,
  output logic      [15:0]                     timeout_ticks
);

  logic [15:0] tmo_r;
  logic [15:0] tmo_nxt;
  logic [crc8rx_pkg::CFG_IDX_W-1:0] reg_idx;
  logic wr_en;

  assign reg_idx = paddr[crc8rx_pkg::CFG_AW-1:2];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    tmo_nxt = tmo_r;
    if (wr_en && reg_idx == crc8rx_pkg::REG_TIMEOUT) begin
      tmo_nxt = pwdata[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tmo_r <= crc8rx_pkg::TIMEOUT_RST;
    end else begin
      tmo_r <= tmo_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == crc8rx_pkg::REG_TIMEOUT) begin
      prdata = {{(crc8rx_pkg::CFG_DW-16){1'b0}}, tmo_r};
    end
  end

  assign timeout_ticks = tmo_r;

endmodule

`default_nettype wire

// ===== design/crc8rx_fsm.sv =====
`default_nettype none

module crc8rx_fsm #(
  parameter int MAX_PAYLOAD = crc8rx_pkg::MAX_PAYLOAD_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  step,
  input  wire crc8rx_pkg::in_item_t  item,
  input  wire logic [15:0]           timeout_ticks,
  output crc8rx_pkg::res_t           res
);

  localparam logic [2:0] PH_HUNT  = 3'd0;
  localparam logic [2:0] PH_SYNC2 = 3'd1;
  localparam logic [2:0] PH_CMD   = 3'd2;
  localparam logic [2:0] PH_LEN   = 3'd3;
  localparam logic [2:0] PH_DATA  = 3'd4;
  localparam logic [2:0] PH_CRC   = 3'd5;

  localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

  logic [2:0]  phase_r, phase_nxt;
  logic [7:0]  crc_r, crc_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [7:0]  seen_r, seen_nxt;
  logic [7:0]  first_r, first_nxt;
  logic [15:0] idle_r, idle_nxt;
  logic [7:0]  link_r, link_nxt;

  logic [7:0]  b;
  logic [7:0]  crc_b;
  logic [15:0] idle_inc;
  logic [7:0]  seen_inc;
  logic        emit;
  logic        kind;
  logic [7:0]  pbyte;
  logic [5:0]  pidx;
  logic [2:0]  status;

  assign b        = item.data_byte;
  assign crc_b    = crc8rx_pkg::crc8_update(crc_r, b);
  assign idle_inc = (idle_r == 16'hFFFF) ? idle_r : idle_r + 16'd1;
  assign seen_inc = seen_r + 8'd1;

  always_comb begin
    phase_nxt = phase_r;
    crc_nxt   = crc_r;
    cmd_nxt   = cmd_r;
    len_nxt   = len_r;
    seen_nxt  = seen_r;
    first_nxt = first_r;
    idle_nxt  = idle_r;
    link_nxt  = link_r;
    emit      = 1'b0;
    kind      = crc8rx_pkg::KIND_END;
    pbyte     = '0;
    pidx      = '0;
    status    = crc8rx_pkg::ST_OK;

    if (item.op == crc8rx_pkg::OP_TICK) begin
      if (phase_r != PH_HUNT) begin
        idle_nxt = idle_inc;
        if (idle_inc >= timeout_ticks) begin
          emit      = 1'b1;
          status    = crc8rx_pkg::ST_TIMEOUT;
          phase_nxt = PH_HUNT;
          idle_nxt  = '0;
        end
      end
    end else begin
      idle_nxt = '0;
      unique case (phase_r)
        PH_HUNT: begin
          if (b == crc8rx_pkg::SYNC_FIRST) begin
            cmd_nxt   = '0;
            len_nxt   = '0;
            phase_nxt = PH_SYNC2;
          end
        end
        PH_SYNC2: begin
          if (b != crc8rx_pkg::SYNC_SECOND) begin
            emit      = 1'b1;
            status    = crc8rx_pkg::ST_SYNC;
            phase_nxt = PH_HUNT;
          end else begin
            crc_nxt   = '0;
            phase_nxt = PH_CMD;
          end
        end
        PH_CMD: begin
          cmd_nxt   = b;
          crc_nxt   = crc_b;
          phase_nxt = PH_LEN;
        end
        PH_LEN: begin
          len_nxt = b;
          crc_nxt = crc_b;
          if (b > MAX_LEN) begin
            emit      = 1'b1;
            status    = crc8rx_pkg::ST_LONG;
            phase_nxt = PH_HUNT;
          end else begin
            seen_nxt  = '0;
            first_nxt = '0;
            phase_nxt = (b == 8'd0) ? PH_CRC : PH_DATA;
          end
        end
        PH_DATA: begin
          crc_nxt = crc_b;
          if (seen_r == 8'd0) begin
            first_nxt = b;
          end
          if (cmd_r != crc8rx_pkg::LINK_CMD) begin
            emit  = 1'b1;
            kind  = crc8rx_pkg::KIND_PAYLOAD;
            pbyte = b;
            pidx  = seen_r[5:0];
          end
          seen_nxt = seen_inc;
          if (seen_inc >= len_r) begin
            phase_nxt = PH_CRC;
          end
        end
        PH_CRC: begin
          emit      = 1'b1;
          phase_nxt = PH_HUNT;
          if (b != crc_r) begin
            status = crc8rx_pkg::ST_CRC;
          end else if (cmd_r == crc8rx_pkg::LINK_CMD) begin
            link_nxt = (len_r != 8'd0) ? first_r : 8'd0;
            status   = crc8rx_pkg::ST_LINK;
          end else begin
            status = crc8rx_pkg::ST_OK;
          end
        end
        default: begin
          phase_nxt = PH_HUNT;
        end
      endcase
    end
  end

  always_comb begin
    res.vld                = step && emit;
    res.item.kind          = kind;
    res.item.payload_byte  = pbyte;
    res.item.payload_index = pidx;
    res.item.command       = cmd_nxt;
    res.item.frame_length  = (len_nxt > crc8rx_pkg::LEN_SAT) ? crc8rx_pkg::LEN_SAT[5:0]
                                                             : len_nxt[5:0];
    res.item.status        = status;
    res.item.link_state    = link_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      crc_r   <= '0;
      cmd_r   <= '0;
      len_r   <= '0;
      seen_r  <= '0;
      first_r <= '0;
      idle_r  <= '0;
      link_r  <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      crc_r   <= crc_nxt;
      cmd_r   <= cmd_nxt;
      len_r   <= len_nxt;
      seen_r  <= seen_nxt;
      first_r <= first_nxt;
      idle_r  <= idle_nxt;
      link_r  <= link_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== test/sync_crc8_frame_receiver_test.sv =====
`default_nettype none

module sync_crc8_frame_receiver_test;
  timeunit 1ns;
  timeprecision 1ps;

  import crc8rx_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASE_ITEMS = 385;
  localparam logic [CFG_AW-1:0] TIMEOUT_ADDR = {REG_TIMEOUT, 2'b00};
  localparam logic [CFG_AW-1:0] SPARE_ADDR = TIMEOUT_ADDR + 3'd4;
  localparam out_item_t NO_RESULT = '0;

  typedef enum logic [2:0] {
    FP_HUNT, FP_SYNC2, FP_CMD, FP_LEN, FP_DATA, FP_CRC
  } frame_phase_t;

  typedef enum logic [1:0] {SRC_LIT, SRC_CRC_GOOD, SRC_CRC_BAD} byte_src_t;

  typedef struct {
    logic      op;
    logic [7:0] data;
    byte_src_t src;
    bit        typed;
    bit        yields;
    out_item_t res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_item_t in_item;
  logic out_valid;
  logic out_ready;
  out_item_t out_item;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic pready;

  // frame receiver state as predicted
  frame_phase_t fr_phase = FP_HUNT;
  logic [7:0] crc_acc = '0;
  logic [7:0] cur_cmd = '0;
  logic [7:0] cur_len = '0;
  logic [7:0] seen_cnt = '0;
  logic [7:0] first_byte = '0;
  logic [15:0] tick_cnt = '0;
  logic [7:0] link_byte = '0;
  logic [15:0] tmo_ticks = TIMEOUT_RST;

  out_item_t pending_results[$];
  int mismatches = 0;
  int items_sent = 0;
  int stall_cycles = 0;
  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  bit row_typed = 1'b0;
  bit row_yields = 1'b0;
  out_item_t row_result = '0;
  stim_row_t dir_rows[0:24];

  sync_crc8_frame_receiver i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // bit-serial crc, msb first
  function automatic logic [7:0] crc07_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] r;
    logic fb;
    r = crc;
    for (int k = 7; k >= 0; k--) begin
      fb = r[7] ^ b[k];
      r = {r[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
    end
    return r;
  endfunction

  function automatic out_item_t frame_item(input logic kind, input logic [7:0] pbyte,
                                           input logic [5:0] pidx, input logic [2:0] st);
    out_item_t r;
    r.kind = kind;
    r.payload_byte = pbyte;
    r.payload_index = pidx;
    r.command = cur_cmd;
    r.frame_length = (cur_len > LEN_SAT) ? LEN_SAT[5:0] : cur_len[5:0];
    r.status = st;
    r.link_state = link_byte;
    return r;
  endfunction

  function automatic void close_frame(input logic [2:0] st, output out_item_t res);
    res = frame_item(KIND_END, 8'h00, 6'd0, st);
    fr_phase = FP_HUNT;
    tick_cnt = '0;
  endfunction

  function automatic bit rx_frame_step(input in_item_t it, output out_item_t res);
    bit hit;
    logic [7:0] b;
    hit = 1'b0;
    b = it.data_byte;
    res = NO_RESULT;
    if (it.op == OP_TICK) begin
      if (fr_phase != FP_HUNT) begin
        if (tick_cnt != 16'hFFFF) tick_cnt++;
        if (tick_cnt >= tmo_ticks) begin
          close_frame(ST_TIMEOUT, res);
          hit = 1'b1;
        end
      end
      return hit;
    end
    tick_cnt = '0;
    case (fr_phase)
      FP_HUNT: begin
        if (b == SYNC_FIRST) begin
          cur_cmd = '0;
          cur_len = '0;
          fr_phase = FP_SYNC2;
        end
      end
      FP_SYNC2: begin
        if (b != SYNC_SECOND) begin
          close_frame(ST_SYNC, res);
          hit = 1'b1;
        end else begin
          crc_acc = '0;
          fr_phase = FP_CMD;
        end
      end
      FP_CMD: begin
        cur_cmd = b;
        crc_acc = crc07_byte(crc_acc, b);
        fr_phase = FP_LEN;
      end
      FP_LEN: begin
        cur_len = b;
        crc_acc = crc07_byte(crc_acc, b);
        if (b > MAX_PAYLOAD_DEF) begin
          close_frame(ST_LONG, res);
          hit = 1'b1;
        end else begin
          seen_cnt = '0;
          first_byte = '0;
          fr_phase = (b == 8'h00) ? FP_CRC : FP_DATA;
        end
      end
      FP_DATA: begin
        crc_acc = crc07_byte(crc_acc, b);
        if (seen_cnt == 8'h00) first_byte = b;
        if (cur_cmd != LINK_CMD) begin
          res = frame_item(KIND_PAYLOAD, b, seen_cnt[5:0], ST_OK);
          hit = 1'b1;
        end
        seen_cnt++;
        if (seen_cnt >= cur_len) fr_phase = FP_CRC;
      end
      FP_CRC: begin
        hit = 1'b1;
        if (b != crc_acc) begin
          close_frame(ST_CRC, res);
        end else if (cur_cmd == LINK_CMD) begin
          link_byte = (cur_len != 8'h00) ? first_byte : 8'h00;
          close_frame(ST_LINK, res);
        end else begin
          close_frame(ST_OK, res);
        end
      end
      default: fr_phase = FP_HUNT;
    endcase
    return hit;
  endfunction

  function automatic out_item_t end_item(input logic [7:0] cmd, input logic [5:0] len,
                                         input logic [2:0] st);
    out_item_t r;
    r = NO_RESULT;
    r.kind = KIND_END;
    r.command = cmd;
    r.frame_length = len;
    r.status = st;
    return r;
  endfunction

  function automatic void cmp_field(input string name, input logic [7:0] want,
                                    input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(negedge clk) begin
    out_ready = ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin : monitor
    out_item_t predicted;
    out_item_t want;
    bit made;
    bit busy;
    busy = 1'b0;
    if (rst_n) begin
      if (psel && penable && pwrite && pready) begin
        busy = 1'b1;
        if (paddr == TIMEOUT_ADDR) tmo_ticks = pwdata[15:0];
      end
      if (in_valid && in_ready) begin
        busy = 1'b1;
        made = rx_frame_step(in_item, predicted);
        if (row_typed) begin
          if (row_yields) pending_results.push_back(row_result);
        end else if (made) begin
          pending_results.push_back(predicted);
        end
      end
      if (out_valid && out_ready) begin
        busy = 1'b1;
        if (pending_results.size() == 0) begin
          $error("result with nothing expected: %p", out_item);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          cmp_field("kind", 8'(want.kind), 8'(out_item.kind));
          cmp_field("payload_byte", want.payload_byte, out_item.payload_byte);
          cmp_field("payload_index", 8'(want.payload_index), 8'(out_item.payload_index));
          cmp_field("command", want.command, out_item.command);
          cmp_field("frame_length", 8'(want.frame_length), 8'(out_item.frame_length));
          cmp_field("status", 8'(want.status), 8'(out_item.status));
          cmp_field("link_state", want.link_state, out_item.link_state);
        end
      end
    end
    stall_cycles = busy ? 0 : stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("sync_crc8_frame_receiver_test failed");
      $finish;
    end
  end

  task automatic send_item(input logic op, input logic [7:0] d, input byte_src_t src,
                           input bit typed = 1'b0, input bit yields = 1'b0,
                           input out_item_t res = '0);
    @(negedge clk);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    case (src)
      SRC_CRC_GOOD: d = crc_acc;
      SRC_CRC_BAD: d = crc_acc ^ (8'h01 << $urandom_range(7));
      default: ;
    endcase
    in_item.op = op;
    in_item.data_byte = d;
    row_typed = typed;
    row_yields = yields;
    row_result = res;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] val);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = addr;
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic cfg_readback();
    logic [CFG_DW-1:0] rd;
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = TIMEOUT_ADDR;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    rd = prdata;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    if (rd !== {16'h0000, tmo_ticks}) begin
      $error("byte_timeout_ticks readback: expected %0h, got %0h", tmo_ticks, rd);
      mismatches++;
    end
  endtask

  // idle ticks ahead of a byte, sometimes right at the timeout boundary
  task automatic tick_gap();
    int r;
    int n;
    r = $urandom_range(99);
    n = 0;
    if (r < 6) n = $urandom_range(1, 4);
    else if (r < 9 && tmo_ticks <= 16'd64) n = int'(tmo_ticks) - 1 + $urandom_range(1);
    repeat (n) send_item(OP_TICK, 8'($urandom), SRC_LIT);
  endtask

  task automatic send_frame();
    int r;
    int len;
    logic [7:0] cmd;
    tick_gap();
    send_item(OP_BYTE, SYNC_FIRST, SRC_LIT);
    tick_gap();
    send_item(OP_BYTE, ($urandom_range(99) < 92) ? SYNC_SECOND : 8'($urandom), SRC_LIT);
    cmd = ($urandom_range(99) < 20) ? LINK_CMD : 8'($urandom);
    tick_gap();
    send_item(OP_BYTE, cmd, SRC_LIT);
    r = $urandom_range(99);
    if (r < 60) len = $urandom_range(0, 8);
    else if (r < 80) len = $urandom_range(9, MAX_PAYLOAD_DEF);
    else if (r < 88) len = MAX_PAYLOAD_DEF;
    else len = $urandom_range(MAX_PAYLOAD_DEF + 1, 255);
    tick_gap();
    send_item(OP_BYTE, 8'(len), SRC_LIT);
    if (len <= MAX_PAYLOAD_DEF) begin
      repeat (len) begin
        tick_gap();
        send_item(OP_BYTE, 8'($urandom), SRC_LIT);
      end
      tick_gap();
      send_item(OP_BYTE, 8'h00, ($urandom_range(99) < 85) ? SRC_CRC_GOOD : SRC_CRC_BAD);
    end
  endtask

  task automatic run_phase(input int gap, input int stall, input int n);
    int start;
    start = items_sent;
    send_gap_pct = gap;
    recv_stall_pct = stall;
    while (items_sent - start < n) begin
      if ($urandom_range(99) < 8) begin
        repeat ($urandom_range(1, 3)) begin
          send_item(($urandom_range(3) == 0) ? OP_TICK : OP_BYTE, 8'($urandom), SRC_LIT);
        end
      end else begin
        send_frame();
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    out_ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    dir_rows = '{
      '{OP_BYTE, 8'h00, SRC_LIT, 1'b1, 1'b0, NO_RESULT},
      '{OP_TICK, 8'hFF, SRC_LIT, 1'b1, 1'b0, NO_RESULT},
      '{OP_BYTE, SYNC_FIRST, SRC_LIT, 1'b1, 1'b0, NO_RESULT},
      '{OP_BYTE, SYNC_FIRST, SRC_LIT, 1'b1, 1'b1, end_item(8'h00, 6'd0, ST_SYNC)},
      '{OP_BYTE, SYNC_FIRST, SRC_LIT, 1'b1, 1'b0, NO_RESULT},
      '{OP_BYTE, SYNC_SECOND, SRC_LIT, 1'b1, 1'b0, NO_RESULT},
      '{OP_BYTE, 8'h12, SRC_LIT, 1'b1, 1'b0, NO_RESULT},
      '{OP_BYTE, 8'hFF, SRC_LIT, 1'b1, 1'b1, end_item(8'h12, 6'd63, ST_LONG)},
      '{OP_BYTE, SYNC_FIRST, SRC_LIT, 1'b1, 1'b0, NO_RESULT},
      '{OP_BYTE, SYNC_SECOND, SRC_LIT, 1'b1, 1'b0, NO_RESULT},
      '{OP_BYTE, 8'h00, SRC_LIT, 1'b1, 1'b0, NO_RESULT},
      '{OP_BYTE, 8'h00, SRC_LIT, 1'b1, 1'b0, NO_RESULT},
      '{OP_BYTE, 8'h00, SRC_LIT, 1'b1, 1'b1, end_item(8'h00, 6'd0, ST_OK)},
      '{OP_BYTE, SYNC_FIRST, SRC_LIT, 1'b1, 1'b0, NO_RESULT},
      '{OP_BYTE, SYNC_SECOND, SRC_LIT, 1'b1, 1'b0, NO_RESULT},
      '{OP_BYTE, LINK_CMD, SRC_LIT, 1'b1, 1'b0, NO_RESULT},
      '{OP_BYTE, 8'h01, SRC_LIT, 1'b1, 1'b0, NO_RESULT},
      '{OP_BYTE, 8'hFF, SRC_LIT, 1'b1, 1'b0, NO_RESULT},
      '{OP_BYTE, 8'h00, SRC_CRC_GOOD, 1'b0, 1'b0, NO_RESULT},
      '{OP_BYTE, SYNC_FIRST, SRC_LIT, 1'b1, 1'b0, NO_RESULT},
      '{OP_BYTE, SYNC_SECOND, SRC_LIT, 1'b1, 1'b0, NO_RESULT},
      '{OP_BYTE, 8'hFF, SRC_LIT, 1'b1, 1'b0, NO_RESULT},
      '{OP_BYTE, 8'h01, SRC_LIT, 1'b1, 1'b0, NO_RESULT},
      '{OP_BYTE, 8'h00, SRC_LIT, 1'b0, 1'b0, NO_RESULT},
      '{OP_BYTE, 8'h00, SRC_CRC_BAD, 1'b0, 1'b0, NO_RESULT}
    };
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    cfg_readback();
    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].op, dir_rows[i].data, dir_rows[i].src,
                dir_rows[i].typed, dir_rows[i].yields, dir_rows[i].res);
    end
    settle();

    run_phase(0, 0, PHASE_ITEMS);
    settle();
    cfg_write(TIMEOUT_ADDR, 32'd1);
    cfg_readback();
    run_phase(52, 0, PHASE_ITEMS);
    settle();
    cfg_write(TIMEOUT_ADDR, 32'd65535);
    cfg_readback();
    run_phase(0, 52, PHASE_ITEMS);
    settle();
    cfg_write(SPARE_ADDR, 32'd2);
    cfg_write(TIMEOUT_ADDR, 32'd5);
    cfg_readback();
    run_phase(11, 11, PHASE_ITEMS);
    settle();
    cfg_write(TIMEOUT_ADDR, 32'd3);
    cfg_readback();
    run_phase(0, 0, PHASE_ITEMS);
    settle();

    if (mismatches == 0) begin
      $display("sync_crc8_frame_receiver_test passed");
    end else begin
      $display("sync_crc8_frame_receiver_test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sync_crc8_frame_receiver.f =====
design/crc8rx_pkg.sv
design/crc8rx_cfg.sv
design/crc8rx_fsm.sv
design/sync_crc8_frame_receiver.sv
test/sync_crc8_frame_receiver_test.sv
